FILE: hdl/particle_pool_update_alloc_assert.svh
// assertion macros for the particle pool checker
// no dependencies
`ifndef PARTICLE_POOL_UPDATE_ALLOC_ASSERT_SVH
`define PARTICLE_POOL_UPDATE_ALLOC_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PP_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// next-cycle implication checked outside reset
`define PP_ASSERT_NXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

FILE: hdl/ppool_pkg.sv
// shared types and constants of the particle pool
// no dependencies
`timescale 1ns / 1ps
package ppool_pkg;
  localparam int DefMaxParticles = 256;
  localparam int SlotW = 8;
  localparam logic [16:0] LifeOne = 17'h10000;
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_ADD = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [15:0] size_w;
    logic [15:0] size_h;
    logic [63:0] color_rgba;
    logic [15:0] texture_id;
    logic [15:0] decay;
  } req_t;

  typedef struct packed {
    logic [7:0] slot_index;
    logic       done_kind;
  } rsp_t;

  // one slot of the store
  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] size;
    logic [63:0] color;
    logic [15:0] tex;
    logic [16:0] life;
    logic [15:0] decay;
  } slot_t;

  localparam int SlotBits = $bits(slot_t);

  function automatic logic [15:0] alpha_sub(input logic [15:0] a, input logic [6:0] d);
    logic signed [17:0] s;
    s = $signed({{2{a[15]}}, a}) - $signed({11'd0, d});
    if (s < -18'sd32768) return 16'h8000;
    return s[15:0];
  endfunction

  function automatic slot_t tick_slot(input slot_t s);
    slot_t r;
    r = s;
    r.life = (s.life > {1'b0, s.decay}) ? s.life - {1'b0, s.decay} : 17'd0;
    r.px = s.px + s.vx;
    r.pz = s.pz + s.vz;
    r.py = s.py + s.vy + s.vz;
    r.color[15:0] = alpha_sub(s.color[15:0], s.decay[15:9]);
    return r;
  endfunction
endpackage

FILE: hdl/ppool_if.sv
// valid/ready channel carrying a payload of type given by parameter
// no dependencies; the payload type comes from the parameter
`timescale 1ns / 1ps
interface ppool_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/ppool_ram.sv
// generic single-port-write, one-read RAM with registered read
// no dependencies
`timescale 1ns / 1ps
module ppool_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/particle_pool_update_alloc.sv
// particle pool top level: slot store, clearing pass, tick walk and free search
// depends on ppool_pkg, ppool_if, ppool_ram
//
// channel | dir | payload
// req     | in  | req_t: req_type, position, velocity, size, color, texture, decay
// rsp     | out | rsp_t: slot_index, done_kind
//
// after reset a clearing pass writes zero to every slot, during which no
// request is taken.
// a tick reads each slot in turn and writes back its updated value.
// an add searches from next_free, one slot read per cycle.
// one request at a time; a result waits in the output register and the
// next request is taken only once that result has been transferred.
`timescale 1ns / 1ps
module particle_pool_update_alloc import ppool_pkg::*; #(
  parameter int MAX_PARTICLES = DefMaxParticles
) (
  input logic clk,
  input logic rst,
  ppool_if.sink   req,
  ppool_if.source rsp
);
  localparam int AW = $clog2(MAX_PARTICLES);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_TICK, S_SEARCH, S_WRITE, S_DONE} state_t;
  state_t state;

  req_t          cur;
  logic [AW-1:0] rd_addr;     // address being presented to the ram
  logic [AW-1:0] cmp_addr;    // address whose data is on rdata
  logic          cmp_vld;
  logic [AW:0]   cnt;         // slots read so far
  logic [AW:0]   seen;        // slots checked so far
  logic [AW-1:0] next_free;
  logic [AW-1:0] wr_addr;
  logic          we;
  slot_t         wdata, rdata, new_slot;

  ppool_ram #(.Width(SlotBits), .Depth(MAX_PARTICLES)) u_ram (
    .clk, .we, .waddr(wr_addr), .wdata, .raddr(rd_addr), .rdata
  );

  always_comb begin
    new_slot = '0;
    new_slot.px = cur.pos_x;
    new_slot.py = cur.pos_y;
    new_slot.pz = cur.pos_z;
    new_slot.vx = cur.vel_x;
    new_slot.vy = cur.vel_y;
    new_slot.vz = cur.vel_z;
    new_slot.size = {cur.size_w, cur.size_h};
    new_slot.color = cur.color_rgba;
    new_slot.tex = cur.texture_id;
    new_slot.life = LifeOne;
    new_slot.decay = cur.decay;
  end

  // idle and no result still waiting in the output register
  assign req.ready = (state == S_IDLE) && !rsp.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      we <= 1'b1;
      wr_addr <= '0;
      wdata <= '0;
      rd_addr <= '0;
      cmp_vld <= 1'b0;
      cnt <= '0;
      seen <= '0;
      next_free <= '0;
      rsp.valid <= 1'b0;
    end else begin
      we <= 1'b0;
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (wr_addr == AW'(MAX_PARTICLES - 1)) state <= S_IDLE;
          else begin
            we <= 1'b1;
            wr_addr <= wr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur <= req.data;
            cnt <= '0;
            seen <= '0;
            cmp_vld <= 1'b0;
            if (req.data.req_type == REQ_ADD) begin
              rd_addr <= next_free;
              state <= S_SEARCH;
            end else begin
              rd_addr <= '0;
              state <= S_TICK;
            end
          end
        end
        S_TICK: begin
          // read one slot per cycle; the updated value is registered into wdata and written back
          if (cnt != (AW+1)'(MAX_PARTICLES)) begin
            cnt <= cnt + 1'b1;
            rd_addr <= rd_addr + 1'b1;
          end
          cmp_vld <= (cnt != (AW+1)'(MAX_PARTICLES));
          cmp_addr <= rd_addr;
          if (cmp_vld) begin
            we <= 1'b1;
            wr_addr <= cmp_addr;
            wdata <= tick_slot(rdata);
          end
          if (cmp_vld && cnt == (AW+1)'(MAX_PARTICLES)) state <= S_DONE;
        end
        S_SEARCH: begin
          // circular walk, wraps at the last slot of the pool
          if (cnt != (AW+1)'(MAX_PARTICLES)) begin
            cnt <= cnt + 1'b1;
            rd_addr <= (rd_addr == AW'(MAX_PARTICLES - 1)) ? '0 : rd_addr + 1'b1;
          end
          cmp_vld <= (cnt != (AW+1)'(MAX_PARTICLES));
          cmp_addr <= rd_addr;
          if (cmp_vld) begin
            seen <= seen + 1'b1;
            if (rdata.life == '0) begin
              wr_addr <= cmp_addr;
              next_free <= cmp_addr;
              state <= S_WRITE;
            end else if (seen == (AW+1)'(MAX_PARTICLES - 1)) begin
              wr_addr <= '0;
              next_free <= '0;
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          we <= 1'b1;
          wdata <= new_slot;
          state <= S_DONE;
        end
        S_DONE: begin
          // wait for the write to land and the output register to free up
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            rsp.data.done_kind <= cur.req_type;
            rsp.data.slot_index <= (cur.req_type == REQ_ADD) ? 8'(wr_addr) : 8'd0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hdl/ppool_chk.sv
// port-level checker for the particle pool, bound to the top level
// depends on ppool_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "particle_pool_update_alloc_assert.svh"
module ppool_chk import ppool_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);
  // one request in flight: no transfer in while a result is pending
  `PP_ASSERT_IMP(a_no_in_with_out, clk, rst, rsp_valid && !rsp_ready, !req_ready, "request taken while result pending")
  // a transfer in is never answered in the very next cycle
  `PP_ASSERT_NXT(a_no_fast_rsp, clk, rst, req_valid && req_ready, !rsp_valid, "result too early")
  // a tick always reports slot zero
  `PP_ASSERT_IMP(a_tick_slot0, clk, rst, rsp_valid && rsp_data.done_kind == REQ_TICK, rsp_data.slot_index == 8'd0, "tick with nonzero slot")
  // stalled result holds
  `PP_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")
endmodule

bind particle_pool_update_alloc ppool_chk u_chk (
  .clk, .rst,
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

FILE: test/tb.sv
// testbench for the particle pool: predicts slot choice and results per request
// depends on ppool_pkg, ppool_if and the particle_pool_update_alloc rtl
`timescale 1ns / 1ps
module tb;
  import ppool_pkg::*;

  localparam int NSLOT = DefMaxParticles;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  ppool_if #(.payload_t(req_t)) req_ch (.clk(clk));
  ppool_if #(.payload_t(rsp_t)) rsp_ch (.clk(clk));

  particle_pool_update_alloc u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // mirror of the pool: only lifetime and decay decide which slot an add gets
  logic [16:0] life_m [NSLOT];
  logic [15:0] decay_m [NSLOT];
  logic [7:0] free_ptr;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  int send_idle_pct = 15;
  int recv_idle_pct = 85;
  int holdoff_cnt = 0;
  int mismatches = 0;
  int n_ticks = 0;
  int n_adds = 0;
  int n_full = 0;

  // apply one accepted request to the mirror and queue its result
  task automatic predict_pool(input req_t r);
    rsp_t e;
    int k;
    int idx;
    bit found;
    found = 1'b0;
    idx = 0;
    if (r.req_type == REQ_TICK) begin
      for (k = 0; k < NSLOT; k++) begin
        life_m[k] = (life_m[k] > {1'b0, decay_m[k]}) ? life_m[k] - {1'b0, decay_m[k]} : 17'd0;
      end
      e.slot_index = 8'd0;
      e.done_kind = 1'b0;
      n_ticks++;
    end else begin
      for (k = 0; k < NSLOT && !found; k++) begin
        if (life_m[(free_ptr + k) % NSLOT] == 17'd0) begin
          idx = (free_ptr + k) % NSLOT;
          found = 1'b1;
        end
      end
      if (!found) n_full++;
      free_ptr = idx[7:0];
      life_m[idx] = LifeOne;
      decay_m[idx] = r.decay;
      e.slot_index = idx[7:0];
      e.done_kind = 1'b1;
      n_adds++;
    end
    expected_rsps = {expected_rsps, e};
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      default: return $urandom();
    endcase
  endfunction

  function automatic req_t make_add(input logic [15:0] dec);
    req_t r;
    r.req_type = REQ_ADD;
    r.pos_x = rand_word();
    r.pos_y = rand_word();
    r.pos_z = rand_word();
    r.vel_x = rand_word();
    r.vel_y = rand_word();
    r.vel_z = rand_word();
    r.size_w = 16'($urandom());
    r.size_h = 16'($urandom());
    r.color_rgba = {$urandom(), $urandom()};
    r.texture_id = 16'($urandom());
    r.decay = dec;
    return r;
  endfunction

  function automatic req_t make_tick();
    req_t r;
    r = make_add(16'($urandom()));
    // payload of a tick is ignored, keep it random anyway
    r.req_type = REQ_TICK;
    return r;
  endfunction

  // driver: offers queued requests, idles at random
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid && req_ch.ready) predict_pool(req_ch.data);
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req_ch.data <= pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // receiver ready, with a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (holdoff_cnt > 0) begin
      holdoff_cnt <= holdoff_cnt - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: each result transfer against the oldest expectation
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: slot %0d kind %0d",
                                       rsp_ch.data.slot_index, rsp_ch.data.done_kind);
      end else begin
        e = expected_rsps.pop_front();
        if (rsp_ch.data.slot_index !== e.slot_index ||
            rsp_ch.data.done_kind !== e.done_kind) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected slot %0d kind %0d, got slot %0d kind %0d",
                     e.slot_index, e.done_kind, rsp_ch.data.slot_index,
                     rsp_ch.data.done_kind);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
      @(posedge clk);
  endtask

  // a random mix of ticks and adds, random decay sizes
  task automatic queue_random(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: pending_reqs = {pending_reqs, make_tick()};
        3: pending_reqs = {pending_reqs, make_add(16'hffff)};
        4: pending_reqs = {pending_reqs, make_add(16'd0)};
        5: pending_reqs = {pending_reqs, make_add(16'($urandom_range(1, 16)))};
        default: pending_reqs = {pending_reqs, make_add(16'($urandom()))};
      endcase
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < NSLOT; i++) begin
      life_m[i] = 17'd0;
      decay_m[i] = 16'd0;
    end
    free_ptr = 8'd0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, tick on empty pool, decay extremes
    pending_reqs = {pending_reqs, make_tick()};
    pending_reqs = {pending_reqs, make_add(16'hffff)};
    pending_reqs = {pending_reqs, make_add(16'd0)};
    pending_reqs = {pending_reqs, make_add(16'h8000)};
    pending_reqs = {pending_reqs, make_add(16'h0200)};
    pending_reqs = {pending_reqs, make_add(16'h0001)};
    pending_reqs = {pending_reqs, make_tick()};
    pending_reqs = {pending_reqs, make_add(16'h1234)};
    pending_reqs = {pending_reqs, make_tick()};
    pending_reqs = {pending_reqs, make_tick()};
    pending_reqs = {pending_reqs, make_add(16'hffff)};
    wait_drained();

    // pool full: fill all slots with zero decay then overflow onto slot 0
    for (i = 0; i < NSLOT + 4; i++) pending_reqs = {pending_reqs, make_add(16'd0)};
    // receiver holds off while adds pile up
    holdoff_cnt = 3000;
    queue_random(400);
    wait_drained();

    send_idle_pct = 85;
    recv_idle_pct = 15;
    queue_random(300);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(300);
    wait_drained();
    repeat (600) @(posedge clk);

    $display("run covered %0d ticks and %0d adds, %0d adds onto a full pool",
             n_ticks, n_adds, n_full);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_rsps.size());
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout");
    $display("Mismatches found");
    $finish;
  end
endmodule
